FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PCT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pct checker: property failed");

// Check a property on every rising clock edge, reset included.
`define PCT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pct checker: property failed during or after reset");

`endif

FILE: rtl/core/pct_pkg.sv
package pct_pkg;

   // Default table dimension (rows and columns).
   localparam int PCT_TABLE_SIZE = 64;

   // Field widths.
   localparam int COUNT_W = 30;
   localparam int QUERY_W = 8;

   // Prime modulus for all counts.
   localparam logic [COUNT_W-1:0] PART_MODULUS = 30'd1000000007;

   // Add two residues and fold once into the modulus range.
   function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PART_MODULUS}) begin
         s = s - {1'b0, PART_MODULUS};
      end
      return s[COUNT_W-1:0];
   endfunction

endpackage

FILE: rtl/core/pct_table.sv
module pct_table #(
   parameter int TABLE_SIZE = pct_pkg::PCT_TABLE_SIZE
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       rd_en,
   input  logic [$clog2(TABLE_SIZE*TABLE_SIZE)-1:0]   rd_addr,
   output logic [pct_pkg::COUNT_W-1:0]                rd_data,
   output logic                                       table_ready
);
   import pct_pkg::*;

   localparam int DEPTH = TABLE_SIZE * TABLE_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(TABLE_SIZE);
   localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

   // Fill sequencer states.
   localparam logic [1:0] ST_ROW0  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   logic [1:0]         state_ff, state_in;
   logic [IW-1:0]      n_ff, n_in;
   logic [IW-1:0]      k_ff, k_in;
   logic [COUNT_W-1:0] left_ff, left_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic               fill_rd;
   logic [AW-1:0]      fill_rd_addr;
   logic [AW-1:0]      mem_rd_addr;
   logic [COUNT_W-1:0] cell_sum;
   logic [IW-1:0]      up_row;

   // Upper source cell: k rows up, same column k.
   assign up_row       = n_ff - k_ff;
   assign fill_rd_addr = AW'(up_row) * AW'(TABLE_SIZE) + AW'(k_ff);
   assign wr_addr      = AW'(n_ff) * AW'(TABLE_SIZE) + AW'(k_ff);
   assign cell_sum     = mod_add(left_ff, (n_ff >= k_ff) ? rd_data_ff : '0);

   // Walk the table row by row; each non-edge cell reads (when k <= n), then writes.
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      left_in  = left_ff;
      wr_en    = 1'b0;
      wr_data  = '0;
      fill_rd  = 1'b0;
      case (state_ff)
         ST_ROW0: begin
            wr_en   = 1'b1;
            wr_data = COUNT_W'(1);
            if (k_ff == LAST) begin
               k_in     = '0;
               n_in     = IW'(1);
               state_in = ST_READ;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         ST_READ: begin
            if (k_ff == '0) begin
               // Column zero of a nonzero row holds zero.
               wr_en   = 1'b1;
               left_in = '0;
               k_in    = IW'(1);
            end else begin
               fill_rd  = (n_ff >= k_ff);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            wr_data  = cell_sum;
            left_in  = cell_sum;
            state_in = ST_READ;
            if (k_ff == LAST) begin
               if (n_ff == LAST) begin
                  state_in = ST_DONE;
               end else begin
                  n_in = n_ff + IW'(1);
                  k_in = '0;
               end
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_DONE;
         end
      endcase
   end

   // Hold sequencer control; clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ROW0;
         n_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
      end
   end

   // Running left-neighbor value.
   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   // Share the single read port between the fill and queries.
   assign mem_rd_addr = fill_rd ? fill_rd_addr : rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_rd || rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign rd_data     = rd_data_ff;
   assign table_ready = (state_ff == ST_DONE);

endmodule

FILE: rtl/core/partition_count_table_unit.sv
// Channel  | Ports                                  | Direction
// ---------+----------------------------------------+----------
// query    | req_valid req_ready req_query_n/k      | in
// result   | rsp_valid rsp_ready rsp_count_mod      | out
//          | rsp_out_of_range                       |
//
// After reset the table fills, paced by its single read port; req_ready is low meanwhile.
// Afterwards one query is taken every cycle unless the result stalls; it passes two
// registers (table read, then result) before its result transaction is offered.
// A stalled result holds in the result register while the read stage keeps
// one more query; reset is synchronous and restarts the fill.
module partition_count_table_unit #(
   parameter int TABLE_SIZE = pct_pkg::PCT_TABLE_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pct_pkg::QUERY_W-1:0]  req_query_n,
   input  logic signed [pct_pkg::QUERY_W-1:0]  req_query_k,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pct_pkg::COUNT_W-1:0]         rsp_count_mod,
   output logic                                rsp_out_of_range
);
   import pct_pkg::*;

   localparam int AW = $clog2(TABLE_SIZE * TABLE_SIZE);
   localparam int IW = $clog2(TABLE_SIZE);

   logic               table_ready;
   logic [COUNT_W-1:0] rd_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   logic               n_neg, k_neg, n_big, k_big, q_oor, q_hit;
   logic               accept;
   logic               out_free, s1_free, s1_adv;

   logic               s1_valid_ff;
   logic               s1_hit_ff;
   logic               s1_oor_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_mod_ff;
   logic               rsp_oor_ff;

   pct_table #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .table_ready (table_ready)
   );

   // Decode the query indexes.
   assign n_neg = req_query_n[QUERY_W-1];
   assign k_neg = req_query_k[QUERY_W-1];
   assign n_big = !n_neg && ({1'b0, req_query_n[QUERY_W-2:0]} >= QUERY_W'(TABLE_SIZE));
   assign k_big = !k_neg && ({1'b0, req_query_k[QUERY_W-2:0]} >= QUERY_W'(TABLE_SIZE));
   assign q_oor = n_big || k_big;
   assign q_hit = !n_neg && !k_neg && !q_oor;

   // Pipeline flow control.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = table_ready && s1_free;
   assign accept    = req_valid && req_ready;

   // Read the table only for in-range queries.
   assign rd_en   = accept && q_hit;
   assign rd_addr = AW'(req_query_n[IW-1:0]) * AW'(TABLE_SIZE) + AW'(req_query_k[IW-1:0]);

   // Read stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff <= q_hit;
         s1_oor_ff <= q_oor;
      end
   end

   // Result register: load on advance, drop on transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_count_mod_ff <= s1_hit_ff ? rd_data : '0;
         rsp_oor_ff       <= s1_oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_mod    = rsp_count_mod_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

FILE: rtl/core/pct_checker.sv
`include "assert_macros.svh"

module pct_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [pct_pkg::QUERY_W-1:0]  req_query_n,
   input logic signed [pct_pkg::QUERY_W-1:0]  req_query_k,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [pct_pkg::COUNT_W-1:0]         rsp_count_mod,
   input logic                                rsp_out_of_range
);
   import pct_pkg::*;

   // A waiting query transaction stays offered with its indexes unchanged.
   `PCT_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid && $stable(req_query_n) && $stable(req_query_k))

   // A stalled result transaction stays offered.
   `PCT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // Every delivered count is a reduced residue.
   `PCT_ASSERT(a_count_reduced, clock, reset, rsp_valid |-> (rsp_count_mod < PART_MODULUS))

   // An out-of-range query always answers zero.
   `PCT_ASSERT(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range |-> (rsp_count_mod == '0))

   // The table fill keeps queries out right after reset.
   `PCT_ASSERT_ALWAYS(a_fill_blocks, clock, $past(reset) |-> !req_ready && !rsp_valid)

endmodule

bind partition_count_table_unit pct_checker u_pct_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_query_n      (req_query_n),
   .req_query_k      (req_query_k),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_count_mod    (rsp_count_mod),
   .rsp_out_of_range (rsp_out_of_range)
);
